// ----- hdl/imhg_pkg.sv -----
// ----------------------------------------------------------------------------
// imhg_pkg
// Shared types and codes for the indexed min-heap of grid cells.
// ----------------------------------------------------------------------------
`default_nettype none

package imhg_pkg;

    localparam int COORD_W  = 6;   // grid coordinate width
    localparam int STATUS_W = 3;
    localparam int GW_W     = 7;   // grid_width register width
    localparam int ADDR_W   = 3;   // APB byte address width
    localparam int DATA_W   = 32;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_GRID_WIDTH = 1'b0;
    localparam logic [GW_W-1:0] GRID_WIDTH_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DELETE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_RANGE     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_GOT_K,
        S_GOT_L,
        S_RISE_RD,
        S_RISE_CMP,
        S_FALL_RD1,
        S_FALL_RD2,
        S_FALL_RD3,
        S_FALL_CMP,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/indexed_min_heap_grid.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_grid
// Indexed binary min-heap of grid cells with a cell-to-slot map.
// ----------------------------------------------------------------------------
// The block holds up to HEAP_DEPTH grid cells, each with a priority, and
// serves the smallest priority first (ties never exchange). Ops: insert, pop
// minimum, delete a cell, query membership; every op returns exactly one
// result word carrying status, the popped cell (pop only), the query answer,
// and the count / empty flag after the op. State lives in two simple
// dual-port synchronous RAMs (one read port, one write port): the heap
// array (slots 1..count) and the slot map indexed by y*grid_width + x. One
// op is in flight at a time; o_in_stall is low only between ops. Range
// rejects and pops of an empty heap go straight to the result; queries and
// duplicate, full or absent rejects first read the slot map; insert swims
// the new entry up from the last slot; pop and delete take the entry out
// and move the last entry into its hole, then sink it (a delete may swim
// it up instead). The walk speed is set by the heap RAM read port, which
// is read once per cycle in the swim/sink walk. After reset the slot map
// is swept to "not present", one entry a cycle (GRID_WIDTH_MAX *
// GRID_HEIGHT_MAX entries, 4096 by default); no words are taken until
// that sweep ends, but APB writes are. grid_width (APB byte address 0)
// is only updated while the heap is empty; values above GRID_WIDTH_MAX
// are capped, and zero makes every cell out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_grid #(
    parameter int HEAP_DEPTH      = 1024,
    parameter int GRID_WIDTH_MAX  = 64,
    parameter int GRID_HEIGHT_MAX = 64,
    parameter int PRIORITY_BITS   = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // APB config port
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire  [imhg_pkg::ADDR_W-1:0]             paddr,
    input  wire  [imhg_pkg::DATA_W-1:0]             pwdata,
    output logic [imhg_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready,
    // request channel
    input  wire                                     i_in_valid,
    output logic                                    o_in_stall,
    input  wire  [1:0]                              i_op,
    input  wire  [imhg_pkg::COORD_W-1:0]            i_pos_x,
    input  wire  [imhg_pkg::COORD_W-1:0]            i_pos_y,
    input  wire  [PRIORITY_BITS-1:0]                i_priority_req,
    // result channel
    output logic                                    o_out_valid,
    input  wire                                     i_out_stall,
    output logic [imhg_pkg::STATUS_W-1:0]           o_status,
    output logic [imhg_pkg::COORD_W-1:0]            o_node_x,
    output logic [imhg_pkg::COORD_W-1:0]            o_node_y,
    output logic [PRIORITY_BITS-1:0]                o_node_priority,
    output logic                                    o_present,
    output logic                                    o_queue_empty,
    output logic [$clog2(HEAP_DEPTH+1)-1:0]         o_entry_count
);
    import imhg_pkg::*;

    localparam int SW        = $clog2(HEAP_DEPTH + 1);        // slot / count width
    localparam int MAP_CELLS = GRID_WIDTH_MAX * GRID_HEIGHT_MAX;
    localparam int MAW       = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
    localparam int WW        = 11;                            // width compare domain

    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic [PRIORITY_BITS-1:0] pri;
    } t_entry;

    // ---------------------------------------------------------------- registers
    t_state              r_state, n_state;
    logic [GW_W-1:0]     r_gw;
    logic [SW-1:0]       r_count, n_count;
    logic [SW-1:0]       r_k, n_k;
    logic [SW-1:0]       r_chk, n_chk;
    t_entry              r_cur, n_cur;    // entry being swum / sunk
    t_entry              r_old, n_old;    // entry being removed
    t_entry              r_ch, n_ch;      // smaller child
    logic                r_ins, n_ins;
    logic                r_moved, n_moved;
    t_op                 r_op, n_op;
    t_status             r_status, n_status;
    logic                r_pres, n_pres;
    logic [COORD_W-1:0]  r_x, n_x;
    logic [COORD_W-1:0]  r_y, n_y;
    logic [PRIORITY_BITS-1:0] r_pri, n_pri;
    logic [MAW-1:0]      r_clr;
    logic                r_ovalid;

    // ---------------------------------------------------------------- memories
    t_entry              heap_mem [HEAP_DEPTH+1];
    logic [SW-1:0]       map_mem  [MAP_CELLS];
    t_entry              heap_rd, heap_wd;
    logic [SW-1:0]       heap_ra, heap_wa;
    logic                heap_we;
    logic [SW-1:0]       map_rd, map_wd;
    logic [MAW-1:0]      map_ra, map_wa;
    logic                map_we;

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        heap_rd <= heap_mem[heap_ra];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd <= map_mem[map_ra];
    end

    // ---------------------------------------------------------------- helpers
    logic [WW-1:0] effw;
    assign effw = ({{(WW-GW_W){1'b0}}, r_gw} > WW'(GRID_WIDTH_MAX)) ?
                  WW'(GRID_WIDTH_MAX) : {{(WW-GW_W){1'b0}}, r_gw};

    function automatic logic [MAW-1:0] cell_of(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [WW-1:0] w);
        logic [17:0] t;
        t = 18'(y) * 18'(w) + 18'(x);
        return MAW'(t);
    endfunction

    logic           in_range;
    logic           out_free;
    logic [SW:0]    fall_c;       // 2k, one bit wider
    logic [SW-1:0]  fall_cs;
    logic           fall_leaf;
    logic           fall_two;
    logic           rise_top;
    logic           rise_swap;
    logic           fall_swap;
    logic           right_less;

    assign in_range   = ({{(WW-COORD_W){1'b0}}, i_pos_x} < effw) &&
                        ({{(WW-COORD_W){1'b0}}, i_pos_y} < WW'(GRID_HEIGHT_MAX));
    assign out_free   = !r_ovalid || !i_out_stall;
    assign fall_c     = {r_k, 1'b0};
    assign fall_cs    = SW'(fall_c);
    assign fall_leaf  = fall_c > {1'b0, r_count};
    assign fall_two   = fall_c < {1'b0, r_count};
    assign rise_top   = (r_k == SW'(1));
    assign rise_swap  = heap_rd.pri > r_cur.pri;
    assign fall_swap  = r_cur.pri > r_ch.pri;
    assign right_less = r_ch.pri > heap_rd.pri;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == MAW'(MAP_CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (t_op'(i_op) == OP_POP) begin
                        n_state = (r_count == '0) ? S_RESP : S_GOT_K;
                    end else if (!in_range) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                case (r_op)
                    OP_INSERT: n_state = (map_rd != '0 || r_count == SW'(HEAP_DEPTH)) ?
                                         S_RESP : S_RISE_RD;
                    OP_DELETE: n_state = (map_rd == '0 || map_rd > r_count) ?
                                         S_RESP : S_GOT_K;
                    default:   n_state = S_RESP;
                endcase
            end
            S_GOT_K:    n_state = S_GOT_L;
            S_GOT_L:    n_state = (r_k == r_count) ? S_RESP : S_RISE_RD;
            S_RISE_RD: begin
                if (!rise_top)               n_state = S_RISE_CMP;
                else if (r_ins || r_moved)   n_state = S_RESP;
                else                         n_state = S_FALL_RD1;
            end
            S_RISE_CMP: begin
                if (rise_swap)               n_state = S_RISE_RD;
                else if (r_ins || r_moved)   n_state = S_RESP;
                else                         n_state = S_FALL_RD1;
            end
            S_FALL_RD1: n_state = fall_leaf ? S_RESP : S_FALL_RD2;
            S_FALL_RD2: n_state = fall_two ? S_FALL_RD3 : S_FALL_CMP;
            S_FALL_RD3: n_state = S_FALL_CMP;
            S_FALL_CMP: n_state = fall_swap ? S_FALL_RD1 : S_RESP;
            S_RESP:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath / memory control
    always_comb begin
        n_count  = r_count;
        n_k      = r_k;
        n_chk    = r_chk;
        n_cur    = r_cur;
        n_old    = r_old;
        n_ch     = r_ch;
        n_ins    = r_ins;
        n_moved  = r_moved;
        n_op     = r_op;
        n_status = r_status;
        n_pres   = r_pres;
        n_x      = r_x;
        n_y      = r_y;
        n_pri    = r_pri;
        heap_ra  = r_k;
        heap_we  = 1'b0;
        heap_wa  = r_k;
        heap_wd  = r_cur;
        map_ra   = cell_of(i_pos_x, i_pos_y, effw);
        map_we   = 1'b0;
        map_wa   = cell_of(r_cur.x, r_cur.y, effw);
        map_wd   = r_k;

        case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                map_wd = '0;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = t_op'(i_op);
                    n_x      = i_pos_x;
                    n_y      = i_pos_y;
                    n_pri    = i_priority_req;
                    n_status = ST_OK;
                    n_pres   = 1'b0;
                    n_ins    = 1'b0;
                    n_moved  = 1'b0;
                    if (t_op'(i_op) == OP_POP) begin
                        if (r_count == '0) n_status = ST_EMPTY;
                        n_k     = SW'(1);
                        heap_ra = SW'(1);
                    end else if (!in_range) begin
                        n_status = ST_RANGE;
                    end
                end
            end
            S_DECIDE: begin
                case (r_op)
                    OP_INSERT: begin
                        if (map_rd != '0) begin
                            n_status = ST_DUPLICATE;
                        end else if (r_count == SW'(HEAP_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count = r_count + SW'(1);
                            n_k     = r_count + SW'(1);
                            n_cur   = '{x: r_x, y: r_y, pri: r_pri};
                            n_ins   = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (map_rd == '0 || map_rd > r_count) begin
                            n_status = ST_ABSENT;
                        end else begin
                            n_k     = map_rd;
                            heap_ra = map_rd;
                        end
                    end
                    default: begin
                        n_pres = (map_rd != '0);
                    end
                endcase
            end
            S_GOT_K: begin
                n_old   = heap_rd;
                heap_ra = r_count;
            end
            S_GOT_L: begin
                // drop the removed cell from the map, last entry fills the hole
                map_we  = 1'b1;
                map_wa  = cell_of(r_old.x, r_old.y, effw);
                map_wd  = '0;
                n_count = r_count - SW'(1);
                n_cur   = heap_rd;
            end
            S_RISE_RD: begin
                heap_ra = r_k >> 1;
                if (rise_top && (r_ins || r_moved)) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end
            end
            S_RISE_CMP: begin
                if (rise_swap) begin
                    heap_we = 1'b1;
                    heap_wd = heap_rd;
                    map_we  = 1'b1;
                    map_wa  = cell_of(heap_rd.x, heap_rd.y, effw);
                    n_k     = r_k >> 1;
                    n_moved = 1'b1;
                end else if (r_ins || r_moved) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end
            end
            S_FALL_RD1: begin
                heap_ra = fall_cs;
                if (fall_leaf) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end
            end
            S_FALL_RD2: begin
                n_ch    = heap_rd;
                n_chk   = fall_cs;
                heap_ra = fall_cs + SW'(1);
            end
            S_FALL_RD3: begin
                if (right_less) begin
                    n_ch  = heap_rd;
                    n_chk = fall_cs + SW'(1);
                end
            end
            S_FALL_CMP: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
                if (fall_swap) begin
                    heap_wd = r_ch;
                    map_wa  = cell_of(r_ch.x, r_ch.y, effw);
                    n_k     = r_chk;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_gw     <= GRID_WIDTH_RESET;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_CLEAR) r_clr <= r_clr + MAW'(1);
            if (psel && penable && pwrite && pready &&
                paddr[2] == CFG_IDX_GRID_WIDTH && r_count == '0) begin
                r_gw <= pwdata[GW_W-1:0];
            end
            if (r_state == S_RESP && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- working / result payload
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_chk    <= n_chk;
        r_cur    <= n_cur;
        r_old    <= n_old;
        r_ch     <= n_ch;
        r_ins    <= n_ins;
        r_moved  <= n_moved;
        r_op     <= n_op;
        r_status <= n_status;
        r_pres   <= n_pres;
        r_x      <= n_x;
        r_y      <= n_y;
        r_pri    <= n_pri;
        if (r_state == S_RESP && out_free) begin
            o_status      <= r_status;
            o_present     <= r_pres;
            o_queue_empty <= (r_count == '0);
            o_entry_count <= r_count;
            if (r_op == OP_POP && r_status == ST_OK) begin
                o_node_x        <= r_old.x;
                o_node_y        <= r_old.y;
                o_node_priority <= r_old.pri;
            end else begin
                o_node_x        <= '0;
                o_node_y        <= '0;
                o_node_priority <= '0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_in_stall  = !(r_state == S_IDLE);
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == CFG_IDX_GRID_WIDTH) ?
                         {{(DATA_W-GW_W){1'b0}}, r_gw} : '0;

    // ---------------------------------------------------------------- assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(HEAP_DEPTH))
        else $error("heap count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR && r_count != $past(r_count)) |->
        (r_count == $past(r_count) + SW'(1) || r_count == $past(r_count) - SW'(1)))
        else $error("count moved by more than one");

    a_walk_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RISE_RD || r_state == S_RISE_CMP || r_state == S_FALL_RD1) |->
        (r_k != '0 && r_k <= r_count))
        else $error("walk slot outside heap");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queue_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_present_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_present) |-> (o_status == ST_OK))
        else $error("present with failing status");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed min-heap of grid cells.
// ----------------------------------------------------------------------------
// Words are sent in random bursts and results are taken under a changing
// stall pattern. A behavioral heap with its own slot map predicts every
// result word, and the monitor compares each result with the oldest
// prediction. Phases run at several grid widths: zero, one, capped, reset
// and odd values. The heap is drained between phases so that the next width
// write takes effect; the last phase fills the heap to capacity.
// ----------------------------------------------------------------------------
module tb;
    import imhg_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int WMAX      = 64;
    localparam int HMAX      = 64;
    localparam int CELLS     = WMAX * HMAX;
    localparam int WDOG_MAX  = 20000;  // covers the slot map sweep and long hold
    localparam int IDX_OTHER = 1;      // register index with no register behind it

    typedef struct packed {
        t_op         op;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [15:0] pri;
    } req_t;

    typedef struct packed {
        t_status     status;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [15:0] pri;
        logic        present;
        logic        empty;
        logic [10:0] count;
    } rsp_t;

    // ---------------- DUT hookup ----------------
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          in_op = '0;
    logic [5:0]          in_x = '0, in_y = '0;
    logic [15:0]         in_pri = '0;
    logic                out_valid;
    logic                out_stall = 1'b1;
    logic [2:0]          out_status;
    logic [5:0]          out_x, out_y;
    logic [15:0]         out_pri;
    logic                out_present, out_empty;
    logic [10:0]         out_count;

    indexed_min_heap_grid i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_op(in_op),
        .i_pos_x(in_x), .i_pos_y(in_y), .i_priority_req(in_pri),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_status(out_status),
        .o_node_x(out_x), .o_node_y(out_y), .o_node_priority(out_pri),
        .o_present(out_present), .o_queue_empty(out_empty),
        .o_entry_count(out_count)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- heap shadow (prediction) ----------------
    logic [5:0]  hx [1:DEPTH];
    logic [5:0]  hy [1:DEPTH];
    logic [15:0] hp [1:DEPTH];
    int          slot_of [CELLS];
    int          hcount = 0;
    int          gw = 64;              // grid_width as written

    function automatic int eff_w();
        return (gw > WMAX) ? WMAX : gw;
    endfunction

    function automatic int cell_at(int x, int y);
        int c;
        c = y * eff_w() + x;
        return (c < CELLS) ? c : 0;
    endfunction

    function automatic bool_gt(int a, int b);
        return hp[a] > hp[b];
    endfunction

    task automatic swap_slots(int a, int b);
        int ca, cb;
        logic [5:0] tx, ty;
        logic [15:0] tp;
        ca = cell_at(hx[a], hy[a]);
        cb = cell_at(hx[b], hy[b]);
        tx = hx[a]; ty = hy[a]; tp = hp[a];
        hx[a] = hx[b]; hy[a] = hy[b]; hp[a] = hp[b];
        hx[b] = tx; hy[b] = ty; hp[b] = tp;
        slot_of[ca] = b;
        slot_of[cb] = a;
    endtask

    task automatic swim(int k);
        while (k > 1 && bool_gt(k / 2, k)) begin
            swap_slots(k, k / 2);
            k = k / 2;
        end
    endtask

    task automatic sink(int k);
        int c;
        while (2 * k <= hcount) begin
            c = 2 * k;
            if (c < hcount && bool_gt(c, c + 1))
                c++;
            if (!bool_gt(k, c))
                break;
            swap_slots(k, c);
            k = c;
        end
    endtask

    task automatic take_slot(int k);
        int c;
        c = cell_at(hx[k], hy[k]);
        swap_slots(k, hcount);
        hcount--;
        slot_of[c] = 0;
        if (k <= hcount) begin
            swim(k);
            sink(k);
        end
    endtask

    // work out the result word for one accepted request word
    task automatic heap_step(input req_t r, output rsp_t e);
        bit in_rng;
        int c, k;
        e = '0;
        e.status = ST_OK;
        in_rng = (r.x < eff_w()) && (r.y < HMAX);
        c = in_rng ? cell_at(r.x, r.y) : 0;
        if (r.op == OP_POP) begin
            if (hcount == 0)
                e.status = ST_EMPTY;
            else begin
                e.x = hx[1]; e.y = hy[1]; e.pri = hp[1];
                take_slot(1);
            end
        end else if (!in_rng)
            e.status = ST_RANGE;
        else if (r.op == OP_INSERT) begin
            if (slot_of[c] != 0)
                e.status = ST_DUPLICATE;
            else if (hcount >= DEPTH)
                e.status = ST_FULL;
            else begin
                hcount++;
                hx[hcount] = r.x; hy[hcount] = r.y; hp[hcount] = r.pri;
                slot_of[c] = hcount;
                swim(hcount);
            end
        end else if (r.op == OP_DELETE) begin
            k = slot_of[c];
            if (k == 0 || k > hcount)
                e.status = ST_ABSENT;
            else
                take_slot(k);
        end else
            e.present = (slot_of[c] != 0);
        e.empty = (hcount == 0);
        e.count = hcount[10:0];
    endtask

    // ---------------- bookkeeping ----------------
    req_t pending_words[$];
    rsp_t expected_words[$];
    int   n_errors = 0, n_sent = 0, n_taken = 0;
    int   status_seen [6];
    int   idle_cycles = 0;
    logic in_taken = 1'b0;

    task automatic report(string what, int want, int got);
        n_errors++;
        $display("mismatch @%0t result %0d: %s expected %0d got %0d",
                 $realtime, n_taken, what, want, got);
    endtask

    // ---------------- driver: bursts and gaps ----------------
    int burst_left = 0, gap_left = 0;

    always @(negedge i_clk) begin
        logic v;
        req_t nxt;
        v = in_valid && !in_taken;
        if (i_rst_n && !v) begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_words.size() > 0) begin
                nxt = pending_words.pop_front();
                v = 1'b1;
                in_op <= nxt.op;
                in_x <= nxt.x;
                in_y <= nxt.y;
                in_pri <= nxt.pri;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else
                    burst_left--;
            end
        end
        in_valid <= v;
    end

    // ---------------- receiver stall pattern ----------------
    int  hold_left = 0, mode = 0, mode_left = 0;
    bit  hold_done = 0;

    always @(negedge i_clk) begin
        logic s;
        // one long hold-off while words keep coming: the block backs up
        if (!hold_done && n_taken >= 900) begin
            hold_done = 1;
            hold_left = 500;
        end
        if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end else
            mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            s = 1'b1;
        end else begin
            case (mode)
                0: s = 1'b0;                                 // free flow
                1: s = ($urandom_range(0, 1) == 1);
                2: s = ($urandom_range(0, 3) == 0);
                default: s = ($urandom_range(0, 7) != 0);    // mostly stalled
            endcase
        end
        out_stall <= s;
    end

    // ---------------- monitor and watchdog ----------------
    always @(posedge i_clk) begin
        rsp_t e;
        req_t r;
        bit act;
        act = 0;
        in_taken <= in_valid && !in_stall;
        if (i_rst_n && in_valid && !in_stall) begin
            r.op = t_op'(in_op); r.x = in_x; r.y = in_y; r.pri = in_pri;
            heap_step(r, e);
            expected_words.push_back(e);
            n_sent++;
            act = 1;
        end
        if (i_rst_n && out_valid && !out_stall) begin
            act = 1;
            n_taken++;
            if (expected_words.size() == 0) begin
                n_errors++;
                $display("mismatch @%0t: result word with nothing expected", $realtime);
            end else begin
                e = expected_words.pop_front();
                if (out_status < 6) status_seen[out_status]++;
                if (out_status !== e.status)   report("status", e.status, out_status);
                if (out_x !== e.x)             report("node_x", e.x, out_x);
                if (out_y !== e.y)             report("node_y", e.y, out_y);
                if (out_pri !== e.pri)         report("node_priority", e.pri, out_pri);
                if (out_present !== e.present) report("present", e.present, out_present);
                if (out_empty !== e.empty)     report("queue_empty", e.empty, out_empty);
                if (out_count !== e.count)     report("entry_count", e.count, out_count);
            end
        end
        idle_cycles = act ? 0 : idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("timeout: %0d cycles with no word moving", WDOG_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    logic [5:0] recent_x [$];
    logic [5:0] recent_y [$];

    task automatic push_word(t_op op, int x, int y, int pri);
        req_t r;
        r.op = op; r.x = 6'(x); r.y = 6'(y); r.pri = 16'(pri);
        pending_words.push_back(r);
        if (op == OP_INSERT) begin
            recent_x.push_back(r.x);
            recent_y.push_back(r.y);
            if (recent_x.size() > 48) begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
        end
    endtask

    // sender pause: nothing queued, nothing in flight, nothing owed
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    endtask

    task automatic apb_write(int idx, int val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(4 * idx); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == 0 && hcount == 0)
            gw = val & 8'h7f;
    endtask

    task automatic random_words(int n);
        int op_sel, x, y, k;
        repeat (n) begin
            op_sel = $urandom_range(0, 99);
            if (recent_x.size() > 0 && $urandom_range(0, 9) < 6) begin
                k = $urandom_range(0, recent_x.size() - 1);
                x = recent_x[k]; y = recent_y[k];
            end else begin
                x = $urandom_range(0, 63); y = $urandom_range(0, 63);
            end
            if (op_sel < 40)
                push_word(OP_INSERT, x, y,
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 65535));
            else if (op_sel < 65) push_word(OP_POP, x, y, $urandom_range(0, 65535));
            else if (op_sel < 85) push_word(OP_DELETE, x, y, $urandom_range(0, 65535));
            else                  push_word(OP_QUERY, x, y, $urandom_range(0, 65535));
        end
    endtask

    // empty the heap so a following width write is honored
    task automatic drain();
        wait_idle();
        repeat (hcount) push_word(OP_POP, $urandom_range(0, 63), $urandom_range(0, 63), 0);
        wait_idle();
    endtask

    initial begin
        int c;
        foreach (slot_of[i]) slot_of[i] = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // write to an unmapped register index: no effect
        apb_write(IDX_OTHER, 5);

        // directed corners at reset width
        push_word(OP_QUERY,  0, 0, 0);
        push_word(OP_POP,    0, 0, 0);           // pop of empty heap
        push_word(OP_DELETE, 9, 9, 0);           // delete of absent cell
        push_word(OP_INSERT, 0, 0, 16'h0000);
        push_word(OP_INSERT, 63, 63, 16'hffff);
        push_word(OP_INSERT, 0, 0, 16'h1234);    // duplicate
        push_word(OP_INSERT, 5, 5, 16'hffff);    // tie with an existing key
        push_word(OP_INSERT, 42, 21, 16'h8000);
        push_word(OP_INSERT, 1, 2, 16'h8000);
        push_word(OP_QUERY,  63, 63, 0);
        push_word(OP_DELETE, 63, 63, 0);
        push_word(OP_QUERY,  63, 63, 0);
        push_word(OP_DELETE, 0, 0, 0);           // delete the root
        repeat (5) push_word(OP_POP, 63, 0, 0);
        drain();

        // zero width: every coordinate is out of range
        apb_write(0, 0);
        push_word(OP_INSERT, 0, 0, 7);
        push_word(OP_DELETE, 0, 0, 0);
        push_word(OP_QUERY,  63, 63, 0);
        push_word(OP_POP,    0, 0, 0);
        wait_idle();

        apb_write(0, 8);
        random_words(150);
        drain();

        apb_write(0, 1);
        random_words(80);
        drain();

        apb_write(0, 37);
        random_words(150);
        drain();

        apb_write(0, 64);
        random_words(80);
        drain();

        // width above the cap: fill to capacity
        apb_write(0, 127);
        for (int i = 0; i < DEPTH; i++) begin
            c = (i * 1021) % CELLS;
            push_word(OP_INSERT, c % 64, c / 64,
                      (i % 4 == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535));
        end
        push_word(OP_INSERT, 0, 0, 1);           // duplicate beats full
        push_word(OP_INSERT, 1, 0, 1);           // duplicate as well
        push_word(OP_INSERT, 2, 0, 1);
        wait_idle();
        apb_write(0, 8);                         // ignored: heap not empty
        random_words(100);
        wait_idle();

        repeat (60) @(posedge i_clk);
        $display("covered %0d words at widths 0, 1, 8, 37, 64 and capped, incl. a full heap",
                 n_sent);
        $display("status counts ok/empty/full/absent/dup/range: %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/imhg_pkg.sv
hdl/indexed_min_heap_grid.sv
sim/tb.sv
